// ----- rtl/core/lc3_instruction_execute_defines.svh -----
// Assertion helpers for the LC-3 execute block.
// Every check is clocked on i_clk and is held off while i_rst_n is low.
`ifndef LC3_INSTRUCTION_EXECUTE_DEFINES_SVH
`define LC3_INSTRUCTION_EXECUTE_DEFINES_SVH

// Same-cycle implication.
`define LC3_IE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LC3_IE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lc3_ie_pkg.sv -----
package lc3_ie_pkg;

    typedef logic [15:0] t_word;
    typedef logic [2:0]  t_reg_idx;

    typedef enum logic [1:0] {
        FN_EXEC = 2'd0,
        FN_HWR  = 2'd1,
        FN_HRD  = 2'd2,
        FN_NOP  = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        OP_BR   = 4'h0,
        OP_ADD  = 4'h1,
        OP_LD   = 4'h2,
        OP_ST   = 4'h3,
        OP_JSR  = 4'h4,
        OP_AND  = 4'h5,
        OP_LDR  = 4'h6,
        OP_STR  = 4'h7,
        OP_RTI  = 4'h8,
        OP_NOT  = 4'h9,
        OP_LDI  = 4'hA,
        OP_STI  = 4'hB,
        OP_JMP  = 4'hC,
        OP_RES  = 4'hD,
        OP_LEA  = 4'hE,
        OP_TRAP = 4'hF
    } t_op;

    typedef enum logic [1:0] {
        CC_NEG  = 2'd0,
        CC_ZERO = 2'd1,
        CC_POS  = 2'd2
    } t_cc;

    localparam t_reg_idx REG_LINK = 3'd7;

    typedef struct packed {
        logic [1:0] func;
        t_word      instr;
        t_word      pc;
        t_word      addr;
        t_word      data;
    } t_in_item;

    typedef struct packed {
        t_word      next_pc;
        logic       reg_written;
        t_reg_idx   reg_index;
        t_word      reg_value;
        logic       mem_written;
        t_word      mem_addr;
        t_word      mem_data;
        logic [1:0] cond_code;
        t_word      read_data;
        logic       unsupported;
    } t_out_item;

    typedef struct packed {
        logic     en;
        t_reg_idx a_idx;
        t_reg_idx b_idx;
    } t_rf_rd;

    typedef struct packed {
        logic     en;
        t_reg_idx idx;
        t_word    data;
    } t_rf_wr;

    function automatic t_word sext_imm5(input t_word ins);
        return {{11{ins[4]}}, ins[4:0]};
    endfunction

    function automatic t_word sext_off6(input t_word ins);
        return {{10{ins[5]}}, ins[5:0]};
    endfunction

    function automatic t_word sext_off9(input t_word ins);
        return {{7{ins[8]}}, ins[8:0]};
    endfunction

    function automatic t_word sext_off11(input t_word ins);
        return {{5{ins[10]}}, ins[10:0]};
    endfunction

    function automatic t_cc flags_of(input t_word v);
        t_cc cc;
        if (v[15]) begin
            cc = CC_NEG;
        end else if (v == 16'h0000) begin
            cc = CC_ZERO;
        end else begin
            cc = CC_POS;
        end
        return cc;
    endfunction

endpackage

// ----- rtl/core/lc3_ie_if.sv -----
interface lc3_ie_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] instr;
    logic [15:0] pc;
    logic [15:0] addr;
    logic [15:0] data;

    modport source (output valid, output func, output instr, output pc, output addr,
                    output data, input ready);
    modport sink   (input valid, input func, input instr, input pc, input addr,
                    input data, output ready);
endinterface

interface lc3_ie_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] next_pc;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_addr;
    logic [15:0] mem_data;
    logic [1:0]  cond_code;
    logic [15:0] read_data;
    logic        unsupported;

    modport source (output valid, output next_pc, output reg_written, output reg_index,
                    output reg_value, output mem_written, output mem_addr,
                    output mem_data, output cond_code, output read_data,
                    output unsupported, input ready);
    modport sink   (input valid, input next_pc, input reg_written, input reg_index,
                    input reg_value, input mem_written, input mem_addr,
                    input mem_data, input cond_code, input read_data,
                    input unsupported, output ready);
endinterface

// ----- rtl/core/lc3_ie_regfile.sv -----
module lc3_ie_regfile import lc3_ie_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_rf_rd i_rd,
    input  t_rf_wr i_wr,
    output t_word  o_a,
    output t_word  o_b
);

    // An entry that was never written since reset reads as zero.
    t_word      r_ram [8];
    logic [7:0] r_vld;
    t_word      r_a_q;
    t_word      r_b_q;
    logic       r_a_v;
    logic       r_b_v;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_ram[i_wr.idx] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_a_q <= r_ram[i_rd.a_idx];
            r_b_q <= r_ram[i_rd.b_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.idx] <= 1'b1;
            end
            if (i_rd.en) begin
                r_a_v <= r_vld[i_rd.a_idx];
                r_b_v <= r_vld[i_rd.b_idx];
            end
        end
    end

    assign o_a = r_a_v ? r_a_q : '0;
    assign o_b = r_b_v ? r_b_q : '0;

endmodule

// ----- rtl/core/lc3_instruction_execute.sv -----
// LC-3 execute block. Each input transaction either executes one LC-3 instruction
// (func 0), writes (func 1) or reads (func 2) one word of the main memory, or does
// nothing (func 3), and produces exactly one output transaction with the next PC, the
// register and memory writes it made, the condition code and any host read word. One
// transaction is buffered at the input while the previous one executes, and results
// wait in an output register. An instruction first issues its register file and
// first memory reads and then executes; LDR and LDI add a memory step for their
// dependent read of the single-port main memory. The next instruction issues only
// after the previous one has written back, and write-back waits while an untaken
// result is held in the output register. The general registers read as zero after
// reset; main memory has no reset and must be written before it is read.
`include "lc3_instruction_execute_defines.svh"

module lc3_instruction_execute import lc3_ie_pkg::*; #(
    parameter int ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lc3_ie_in_if.sink   i_in,
    lc3_ie_out_if.source o_out
);

    localparam int MEM_WORDS = 1 << ADDR_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MEM
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_cc       r_cc;
    t_cc       n_cc;
    logic      r_ov;
    t_out_item r_o;
    t_out_item res;

    logic      r_hv;
    t_in_item  r_h;
    t_in_item  r_w;

    logic      take;
    logic      in_acc;
    logic      out_free;
    logic      done;
    logic      fin;

    t_op       h_op;
    t_op       w_op;
    t_rf_rd    rf_rd;
    t_rf_wr    rf_wr;
    t_word     rf_a;
    t_word     rf_b;

    t_word     r_mem [MEM_WORDS];
    t_word     r_mem_q;
    logic      iss_re;
    t_word     iss_addr;
    logic      ex_re;
    t_word     ex_addr;
    logic      mem_re;
    logic [ADDR_BITS-1:0] mem_ra;
    logic      mem_we;
    t_word     wa_full;
    logic [ADDR_BITS-1:0] mem_wa;

    t_word     w_off9_sum;
    t_word     w_off6_sum;
    t_word     w_bval;
    logic [2:0] w_nzp;
    logic      br_take;

    assign in_acc      = i_in.valid && i_in.ready;
    assign take        = (r_state == S_IDLE) && r_hv;
    assign i_in.ready  = !r_hv || take;
    assign out_free    = !r_ov || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else if (in_acc) begin
            r_hv <= 1'b1;
        end else if (take) begin
            r_hv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_h <= '{func: i_in.func, instr: i_in.instr, pc: i_in.pc,
                     addr: i_in.addr, data: i_in.data};
        end
        if (take) begin
            r_w <= r_h;
        end
    end

    // Issue: register file and first memory read from the buffered transaction.
    always_comb begin
        h_op           = t_op'(r_h.instr[15:12]);
        rf_rd.en       = take;
        rf_rd.a_idx    = r_h.instr[8:6];
        if (h_op == OP_ST || h_op == OP_STI || h_op == OP_STR) begin
            rf_rd.b_idx = r_h.instr[11:9];
        end else begin
            rf_rd.b_idx = r_h.instr[2:0];
        end
        iss_re   = 1'b0;
        iss_addr = r_h.pc + sext_off9(r_h.instr);
        if (take) begin
            case (r_h.func)
                FN_EXEC: begin
                    case (h_op) inside
                        OP_LD, OP_LDI, OP_STI: iss_re = 1'b1;
                        OP_TRAP: begin
                            iss_re   = 1'b1;
                            iss_addr = {8'h00, r_h.instr[7:0]};
                        end
                        default: iss_re = 1'b0;
                    endcase
                end
                FN_HRD: begin
                    iss_re   = 1'b1;
                    iss_addr = r_h.addr;
                end
                default: iss_re = 1'b0;
            endcase
        end
    end

    lc3_ie_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rf_rd),
        .i_wr    (rf_wr),
        .o_a     (rf_a),
        .o_b     (rf_b)
    );

    // Execute and write-back.
    always_comb begin
        w_op       = t_op'(r_w.instr[15:12]);
        w_off9_sum = r_w.pc + sext_off9(r_w.instr);
        w_off6_sum = rf_a + sext_off6(r_w.instr);
        w_bval     = r_w.instr[5] ? sext_imm5(r_w.instr) : rf_b;
        w_nzp      = r_w.instr[11:9];
        br_take    = (w_nzp[2] && r_cc == CC_NEG) || (w_nzp[1] && r_cc == CC_ZERO) ||
                     (w_nzp[0] && r_cc == CC_POS);

        res         = '0;
        res.next_pc = r_w.pc;
        n_cc        = r_cc;
        n_state     = r_state;
        done        = 1'b0;
        ex_re       = 1'b0;
        ex_addr     = r_mem_q;
        wa_full     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                done = 1'b1;
                case (r_w.func)
                    FN_HWR: begin
                        res.mem_written = 1'b1;
                        wa_full         = r_w.addr;
                        res.mem_data    = r_w.data;
                    end
                    FN_HRD: res.read_data = r_mem_q;
                    FN_NOP: done = 1'b1;
                    default: begin
                        unique case (w_op)
                            OP_BR: begin
                                if (br_take) begin
                                    res.next_pc = w_off9_sum;
                                end
                            end
                            OP_ADD: begin
                                res.reg_written = 1'b1;
                                res.reg_index   = r_w.instr[11:9];
                                res.reg_value   = rf_a + w_bval;
                            end
                            OP_AND: begin
                                res.reg_written = 1'b1;
                                res.reg_index   = r_w.instr[11:9];
                                res.reg_value   = rf_a & w_bval;
                            end
                            OP_NOT: begin
                                res.reg_written = 1'b1;
                                res.reg_index   = r_w.instr[11:9];
                                res.reg_value   = ~rf_a;
                            end
                            OP_LEA: begin
                                res.reg_written = 1'b1;
                                res.reg_index   = r_w.instr[11:9];
                                res.reg_value   = w_off9_sum;
                            end
                            OP_LD: begin
                                res.reg_written = 1'b1;
                                res.reg_index   = r_w.instr[11:9];
                                res.reg_value   = r_mem_q;
                            end
                            OP_LDI: begin
                                done    = 1'b0;
                                ex_re   = 1'b1;
                                ex_addr = r_mem_q;
                                n_state = S_MEM;
                            end
                            OP_LDR: begin
                                done    = 1'b0;
                                ex_re   = 1'b1;
                                ex_addr = w_off6_sum;
                                n_state = S_MEM;
                            end
                            OP_ST: begin
                                res.mem_written = 1'b1;
                                wa_full         = w_off9_sum;
                                res.mem_data    = rf_b;
                            end
                            OP_STI: begin
                                res.mem_written = 1'b1;
                                wa_full         = r_mem_q;
                                res.mem_data    = rf_b;
                            end
                            OP_STR: begin
                                res.mem_written = 1'b1;
                                wa_full         = w_off6_sum;
                                res.mem_data    = rf_b;
                            end
                            OP_JMP: res.next_pc = rf_a;
                            OP_JSR: begin
                                res.next_pc     = r_w.instr[11]
                                                ? r_w.pc + sext_off11(r_w.instr) : rf_a;
                                res.reg_written = 1'b1;
                                res.reg_index   = REG_LINK;
                                res.reg_value   = r_w.pc;
                            end
                            OP_TRAP: begin
                                res.next_pc     = r_mem_q;
                                res.reg_written = 1'b1;
                                res.reg_index   = REG_LINK;
                                res.reg_value   = r_w.pc;
                            end
                            OP_RTI, OP_RES: res.unsupported = 1'b1;
                        endcase
                    end
                endcase
            end
            S_MEM: begin
                done            = 1'b1;
                res.reg_written = 1'b1;
                res.reg_index   = r_w.instr[11:9];
                res.reg_value   = r_mem_q;
            end
        endcase

        mem_wa       = wa_full[ADDR_BITS-1:0];
        res.mem_addr = 16'(mem_wa);
        if (r_w.func == FN_EXEC && res.reg_written && w_op != OP_JSR && w_op != OP_TRAP) begin
            n_cc = flags_of(res.reg_value);
        end
        res.cond_code = n_cc;

        fin = done && out_free;
        if (fin) begin
            n_state = S_IDLE;
        end

        rf_wr.en   = fin && res.reg_written;
        rf_wr.idx  = res.reg_index;
        rf_wr.data = res.reg_value;
        mem_we     = fin && res.mem_written;
    end

    assign mem_re = iss_re || ex_re;
    assign mem_ra = iss_re ? iss_addr[ADDR_BITS-1:0] : ex_addr[ADDR_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= res.mem_data;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cc    <= CC_ZERO;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin) begin
                r_cc <= n_cc;
                r_ov <= 1'b1;
                r_o  <= res;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.next_pc     = r_o.next_pc;
    assign o_out.reg_written = r_o.reg_written;
    assign o_out.reg_index   = r_o.reg_index;
    assign o_out.reg_value   = r_o.reg_value;
    assign o_out.mem_written = r_o.mem_written;
    assign o_out.mem_addr    = r_o.mem_addr;
    assign o_out.mem_data    = r_o.mem_data;
    assign o_out.cond_code   = r_o.cond_code;
    assign o_out.read_data   = r_o.read_data;
    assign o_out.unsupported = r_o.unsupported;

    `LC3_IE_ASSERT_IMP(a_mem_port_single, mem_we, !mem_re, "memory read and write in one cycle")
    `LC3_IE_ASSERT_IMP(a_fin_slot_free, fin, !r_ov || o_out.ready, "result overwrites a waiting result")
    `LC3_IE_ASSERT_IMP(a_unsup_quiet, o_out.valid && o_out.unsupported, !o_out.reg_written && !o_out.mem_written, "unsupported opcode changed state")
    `LC3_IE_ASSERT_IMP(a_mem_from_exec, r_state == S_MEM, $past(r_state) == S_EXEC || $past(r_state) == S_MEM, "second read entered without execute")
    `LC3_IE_ASSERT_NXT(a_accept_buffers, in_acc, r_hv, "accepted transaction not buffered")

endmodule
